>>> src/let_pkg.sv
// ----------------------------------------------------------------------------
// let_pkg
// Shared widths, register indexes and result kinds for the link expiration
// time pipeline.
// ----------------------------------------------------------------------------
package let_pkg;

    // time fraction bits (seconds in q.10)
    localparam int TFB = 10;

    // field widths
    localparam int POS_W   = 32;
    localparam int VEL_W   = 24;
    localparam int ELA_W   = 24;
    localparam int CR_W    = 24;
    localparam int TO_W    = 20;
    localparam int OUT_W   = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // clamp limit for extrapolated position and relative velocity
    localparam int CLAMP_LIM = 2 ** 30;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COMM_RANGE          = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELIABILITY_TIMEOUT = 2'd1;

    // how the final result is formed
    typedef enum logic [1:0] {
        KIND_ZERO = 2'd0,
        KIND_ONE  = 2'd1,
        KIND_CALC = 2'd2
    } kind_t;

endpackage

>>> src/let_div.sv
// ----------------------------------------------------------------------------
// let_div
// Pipelined restoring divider, one quotient bit per stage. Gives a Q_W-bit
// quotient when it fits and flags overflow when the quotient does not fit.
// ----------------------------------------------------------------------------
module let_div #(
    parameter int N_W   = 42,
    parameter int D_W   = 20,
    parameter int Q_W   = 32,
    parameter int TAG_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [N_W-1:0]   dividend,
    input  logic [D_W-1:0]   divisor,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [Q_W-1:0]   quotient,
    output logic             overflow,
    output logic [TAG_W-1:0] out_tag
);

    localparam int HI_W = N_W - Q_W;
    localparam int CW   = (HI_W > D_W) ? HI_W : D_W;

    logic             valid_reg [0:Q_W];
    logic [D_W-1:0]   rem_reg   [0:Q_W];
    logic [Q_W-1:0]   low_reg   [0:Q_W];
    logic [Q_W-1:0]   quo_reg   [0:Q_W];
    logic [D_W-1:0]   dvs_reg   [0:Q_W];
    logic             ovf_reg   [0:Q_W];
    logic [TAG_W-1:0] tag_reg   [0:Q_W];

    logic [CW-1:0]  hi_ext;
    logic [CW-1:0]  dvs_ext;
    logic           ovf_next;
    logic [D_W-1:0] rem0_next;

    // entry: upper dividend bits must stay below the divisor
    assign hi_ext    = CW'(dividend[N_W-1:Q_W]);
    assign dvs_ext   = CW'(divisor);
    assign ovf_next  = (hi_ext >= dvs_ext);
    assign rem0_next = ovf_next ? '0 : D_W'(hi_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= rem0_next;
        low_reg[0] <= dividend[Q_W-1:0];
        quo_reg[0] <= '0;
        dvs_reg[0] <= divisor;
        ovf_reg[0] <= ovf_next;
        tag_reg[0] <= in_tag;
    end

    // one compare and subtract per stage
    for (genvar k = 1; k <= Q_W; k++)
    begin : g_step
        logic [D_W:0]   trial;
        logic [D_W:0]   diff;
        logic           ge;
        logic [D_W-1:0] rem_next;
        logic [Q_W-1:0] quo_next;

        assign trial    = {rem_reg[k-1], low_reg[k-1][Q_W-1]};
        assign ge       = (trial >= {1'b0, dvs_reg[k-1]});
        assign diff     = trial - {1'b0, dvs_reg[k-1]};
        assign rem_next = ge ? diff[D_W-1:0] : trial[D_W-1:0];
        assign quo_next = {quo_reg[k-1][Q_W-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= rem_next;
            low_reg[k] <= low_reg[k-1] << 1;
            quo_reg[k] <= quo_next;
            dvs_reg[k] <= dvs_reg[k-1];
            ovf_reg[k] <= ovf_reg[k-1];
            tag_reg[k] <= tag_reg[k-1];
        end
    end

    assign out_valid = valid_reg[Q_W];
    assign quotient  = quo_reg[Q_W];
    assign overflow  = ovf_reg[Q_W];
    assign out_tag   = tag_reg[Q_W];

endmodule

>>> src/let_sqrt.sv
// ----------------------------------------------------------------------------
// let_sqrt
// Pipelined integer square root, one root bit per stage, floor result.
// ----------------------------------------------------------------------------
module let_sqrt #(
    parameter int R_W   = 64,
    parameter int TAG_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [2*R_W-1:0] radicand,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [R_W-1:0]   root,
    output logic [TAG_W-1:0] out_tag
);

    localparam int REM_W = R_W + 2;

    logic             valid_reg [0:R_W];
    logic [2*R_W-1:0] rad_reg   [0:R_W];
    logic [REM_W-1:0] rem_reg   [0:R_W];
    logic [R_W-1:0]   root_reg  [0:R_W];
    logic [TAG_W-1:0] tag_reg   [0:R_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg[0]  <= radicand;
        rem_reg[0]  <= '0;
        root_reg[0] <= '0;
        tag_reg[0]  <= in_tag;
    end

    // bring down two radicand bits, try root*4+1
    for (genvar k = 1; k <= R_W; k++)
    begin : g_step
        logic [REM_W-1:0] shifted;
        logic [REM_W-1:0] trial;
        logic             ge;
        logic [REM_W-1:0] rem_next;
        logic [R_W-1:0]   root_next;

        assign shifted   = {rem_reg[k-1][R_W-1:0], rad_reg[k-1][2*R_W-1 -: 2]};
        assign trial     = {root_reg[k-1], 2'b01};
        assign ge        = (shifted >= trial);
        assign rem_next  = ge ? (shifted - trial) : shifted;
        assign root_next = {root_reg[k-1][R_W-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            rad_reg[k]  <= rad_reg[k-1] << 2;
            rem_reg[k]  <= rem_next;
            root_reg[k] <= root_next;
            tag_reg[k]  <= tag_reg[k-1];
        end
    end

    assign out_valid = valid_reg[R_W];
    assign root      = root_reg[R_W];
    assign out_tag   = tag_reg[R_W];

endmodule

>>> src/link_expiration_time.sv
// ----------------------------------------------------------------------------
// link_expiration_time
// Predicts when a neighbor leaves communication range by solving
// |p + v t| = range on a fully pipelined fixed-point datapath.
// ----------------------------------------------------------------------------
// throughput: one request per cycle, busy stays low, results cannot be stalled
// the path from the accepting edge to the done strobe runs through the
// 32-stage velocity dividers, the 64-stage square root and the
// 32-stage time divider, one bit per stage each
// reset clears all valid bits and loads comm_range 64000, timeout 1024
// ----------------------------------------------------------------------------
module link_expiration_time (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic signed [31:0] rel_pos_x,
    input  logic signed [31:0] rel_pos_y,
    input  logic signed [31:0] rel_pos_z,
    input  logic signed [23:0] nbr_vel_x,
    input  logic signed [23:0] nbr_vel_y,
    input  logic signed [23:0] nbr_vel_z,
    input  logic [23:0] elapsed,
    input  logic signed [31:0] own_disp_x,
    input  logic signed [31:0] own_disp_y,
    input  logic signed [31:0] own_disp_z,
    output logic        done,
    output logic [31:0] expiry_time,
    output logic        saturated,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    localparam int POS_W = let_pkg::POS_W;
    localparam int VEL_W = let_pkg::VEL_W;
    localparam int TFB   = let_pkg::TFB;
    localparam int MW    = VEL_W + let_pkg::ELA_W + 1;
    localparam int VTAG_W = POS_W + VEL_W + 1;
    localparam int STAG_W = 2 + 1 + 62 + 62;

    localparam logic signed [MW-1:0] P_HI = MW'(let_pkg::CLAMP_LIM);
    localparam logic signed [MW-1:0] P_LO = -MW'(let_pkg::CLAMP_LIM);
    localparam logic signed [34:0]   V_HI = 35'(let_pkg::CLAMP_LIM);
    localparam logic signed [34:0]   V_LO = -35'(let_pkg::CLAMP_LIM);

    // configuration
    logic [let_pkg::CR_W-1:0] comm_range_reg;
    logic [let_pkg::TO_W-1:0] timeout_reg;
    logic [2*let_pkg::CR_W-1:0] rr_reg;
    logic [let_pkg::TO_W-1:0] t_div;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comm_range_reg <= let_pkg::CR_W'(64000);
            timeout_reg    <= let_pkg::TO_W'(1024);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                let_pkg::CFG_COMM_RANGE:
                    comm_range_reg <= cfg_data[let_pkg::CR_W-1:0];
                let_pkg::CFG_RELIABILITY_TIMEOUT:
                    timeout_reg <= cfg_data[let_pkg::TO_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // range squared, refreshed every cycle
    always_ff @(posedge clk)
    begin
        rr_reg <= (2*let_pkg::CR_W)'(comm_range_reg) * (2*let_pkg::CR_W)'(comm_range_reg);
    end

    assign t_div = (timeout_reg == '0) ? let_pkg::TO_W'(1 << TFB) : timeout_reg;

    // per-axis input views
    logic signed [POS_W-1:0] rel_in  [3];
    logic signed [VEL_W-1:0] vel_in  [3];
    logic signed [POS_W-1:0] disp_in [3];

    assign rel_in[0]  = rel_pos_x;
    assign rel_in[1]  = rel_pos_y;
    assign rel_in[2]  = rel_pos_z;
    assign vel_in[0]  = nbr_vel_x;
    assign vel_in[1]  = nbr_vel_y;
    assign vel_in[2]  = nbr_vel_z;
    assign disp_in[0] = own_disp_x;
    assign disp_in[1] = own_disp_y;
    assign disp_in[2] = own_disp_z;

    // valid chain outside the units
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;
    logic done_reg;
    logic dv_valid [3];
    logic sq_valid;
    logic td_valid;

    // stage 1: request capture
    logic signed [POS_W-1:0] rel1_reg  [3];
    logic signed [VEL_W-1:0] vj1_reg   [3];
    logic signed [POS_W-1:0] disp1_reg [3];
    logic [let_pkg::ELA_W-1:0] ela1_reg;

    // stage 2: neighbor drift product, displacement magnitude
    logic signed [MW-1:0]    prod2_reg [3];
    logic signed [POS_W-1:0] rel2_reg  [3];
    logic signed [VEL_W-1:0] vj2_reg   [3];
    logic [POS_W-1:0]        dmag2_reg [3];
    logic                    dneg2_reg [3];

    // divider outputs
    logic [31:0]       dv_q   [3];
    logic              dv_ovf [3];
    logic [VTAG_W-1:0] dv_tag [3];

    // stage 3 .. 4: clamped p and v, then products
    logic signed [31:0] p3_reg  [3];
    logic signed [31:0] vv3_reg [3];
    logic signed [63:0] pv4_reg [3];
    logic signed [63:0] vq4_reg [3];
    logic signed [63:0] pq4_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            v7_reg   <= 1'b0;
            v8_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start && !busy;
            v2_reg   <= v1_reg;
            v3_reg   <= dv_valid[0] && dv_valid[1] && dv_valid[2];
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            v6_reg   <= v5_reg;
            v7_reg   <= v6_reg;
            v8_reg   <= v7_reg;
            done_reg <= td_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ela1_reg <= elapsed;
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_axis
        logic signed [MW-1:0]    prod2_next;
        logic [POS_W-1:0]        dmag2_next;
        logic signed [MW-1:0]    p_sum;
        logic signed [31:0]      p_cl;
        logic [POS_W+TFB-1:0]    dvd;
        logic signed [31:0]      p_back;
        logic signed [VEL_W-1:0] vj_back;
        logic                    dneg_back;
        logic signed [34:0]      vi_s;
        logic signed [34:0]      v_diff;
        logic signed [31:0]      v3_next;

        // drift over the elapsed time
        assign prod2_next = MW'(vj1_reg[i]) * MW'($signed({1'b0, ela1_reg}));
        assign dmag2_next = disp1_reg[i][POS_W-1] ? (~disp1_reg[i] + 1'b1) : disp1_reg[i];

        always_ff @(posedge clk)
        begin
            rel1_reg[i]  <= rel_in[i];
            vj1_reg[i]   <= vel_in[i];
            disp1_reg[i] <= disp_in[i];
            prod2_reg[i] <= prod2_next;
            rel2_reg[i]  <= rel1_reg[i];
            vj2_reg[i]   <= vj1_reg[i];
            dmag2_reg[i] <= dmag2_next;
            dneg2_reg[i] <= disp1_reg[i][POS_W-1];
        end

        // extrapolated position, clamped
        assign p_sum = MW'(rel2_reg[i]) + (prod2_reg[i] >>> TFB);
        assign p_cl  = (p_sum > P_HI) ? 32'(P_HI) :
                       (p_sum < P_LO) ? 32'(P_LO) : p_sum[31:0];
        assign dvd   = {dmag2_reg[i], {TFB{1'b0}}};

        // own velocity magnitude: displacement over timeout
        let_div #(
            .N_W   (POS_W + TFB),
            .D_W   (let_pkg::TO_W),
            .Q_W   (32),
            .TAG_W (VTAG_W)
        ) u_vdiv (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v2_reg),
            .dividend  (dvd),
            .divisor   (t_div),
            .in_tag    ({p_cl, vj2_reg[i], dneg2_reg[i]}),
            .out_valid (dv_valid[i]),
            .quotient  (dv_q[i]),
            .overflow  (dv_ovf[i]),
            .out_tag   (dv_tag[i])
        );

        assign p_back    = dv_tag[i][VTAG_W-1 -: 32];
        assign vj_back   = dv_tag[i][VEL_W:1];
        assign dneg_back = dv_tag[i][0];

        // relative velocity, clamped
        assign vi_s    = dneg_back ? -$signed({3'b0, dv_q[i]}) : $signed({3'b0, dv_q[i]});
        assign v_diff  = 35'(vj_back) - vi_s;
        assign v3_next = dv_ovf[i] ? (dneg_back ? 32'(V_HI) : 32'(V_LO)) :
                         (v_diff > V_HI) ? 32'(V_HI) :
                         (v_diff < V_LO) ? 32'(V_LO) : v_diff[31:0];

        always_ff @(posedge clk)
        begin
            p3_reg[i]  <= p_back;
            vv3_reg[i] <= v3_next;
            pv4_reg[i] <= 64'(p3_reg[i]) * 64'(vv3_reg[i]);
            vq4_reg[i] <= 64'(vv3_reg[i]) * 64'(vv3_reg[i]);
            pq4_reg[i] <= 64'(p3_reg[i]) * 64'(p3_reg[i]);
        end
    end

    // stage 5: quadratic coefficients
    logic signed [63:0] a_sum;
    logic signed [63:0] h_sum;
    logic signed [63:0] c_next;
    logic [61:0]        a5_reg;
    logic signed [62:0] h5_reg;
    logic signed [63:0] c5_reg;

    assign a_sum  = vq4_reg[0] + vq4_reg[1] + vq4_reg[2];
    assign h_sum  = pv4_reg[0] + pv4_reg[1] + pv4_reg[2];
    assign c_next = pq4_reg[0] + pq4_reg[1] + pq4_reg[2] - $signed({16'b0, rr_reg});

    always_ff @(posedge clk)
    begin
        a5_reg <= a_sum[61:0];
        h5_reg <= h_sum[62:0];
        c5_reg <= c_next;
    end

    // stage 6: case selection and magnitudes
    let_pkg::kind_t kind6_next;
    let_pkg::kind_t kind6_reg;
    logic [61:0] hmag6_reg;
    logic        hneg6_reg;
    logic [61:0] a6_reg;
    logic [47:0] nc6_reg;
    logic signed [62:0] h_abs;
    logic signed [63:0] c_neg;

    always_comb
    begin
        if (a5_reg == '0)
        begin
            kind6_next = c5_reg[63] ? let_pkg::KIND_ONE : let_pkg::KIND_ZERO;
        end
        else
        begin
            kind6_next = c5_reg[63] ? let_pkg::KIND_CALC : let_pkg::KIND_ZERO;
        end
    end

    assign h_abs = h5_reg[62] ? -h5_reg : h5_reg;
    assign c_neg = -c5_reg;

    always_ff @(posedge clk)
    begin
        kind6_reg <= kind6_next;
        hmag6_reg <= h_abs[61:0];
        hneg6_reg <= h5_reg[62];
        a6_reg    <= a5_reg;
        nc6_reg   <= c_neg[47:0];
    end

    // stage 7: partial products of h^2 and a*(-c)
    logic [63:0] hlhl7_reg;
    logic [61:0] hlhh7_reg;
    logic [59:0] hhhh7_reg;
    logic [63:0] alnl7_reg;
    logic [47:0] alnh7_reg;
    logic [61:0] ahnl7_reg;
    logic [45:0] ahnh7_reg;
    let_pkg::kind_t kind7_reg;
    logic [61:0] hmag7_reg;
    logic        hneg7_reg;
    logic [61:0] a7_reg;

    always_ff @(posedge clk)
    begin
        hlhl7_reg <= 64'(hmag6_reg[31:0]) * 64'(hmag6_reg[31:0]);
        hlhh7_reg <= 62'(hmag6_reg[31:0]) * 62'(hmag6_reg[61:32]);
        hhhh7_reg <= 60'(hmag6_reg[61:32]) * 60'(hmag6_reg[61:32]);
        alnl7_reg <= 64'(a6_reg[31:0]) * 64'(nc6_reg[31:0]);
        alnh7_reg <= 48'(a6_reg[31:0]) * 48'(nc6_reg[47:32]);
        ahnl7_reg <= 62'(a6_reg[61:32]) * 62'(nc6_reg[31:0]);
        ahnh7_reg <= 46'(a6_reg[61:32]) * 46'(nc6_reg[47:32]);
        kind7_reg <= kind6_reg;
        hmag7_reg <= hmag6_reg;
        hneg7_reg <= hneg6_reg;
        a7_reg    <= a6_reg;
    end

    // stage 8: assemble both wide products
    logic [127:0] h2_next;
    logic [127:0] ac_next;
    logic [127:0] h28_reg;
    logic [127:0] ac8_reg;
    let_pkg::kind_t kind8_reg;
    logic [61:0] hmag8_reg;
    logic        hneg8_reg;
    logic [61:0] a8_reg;

    assign h2_next = (128'(hhhh7_reg) << 64) + (128'(hlhh7_reg) << 33) + 128'(hlhl7_reg);
    assign ac_next = (128'(ahnh7_reg) << 64) + ((128'(alnh7_reg) + 128'(ahnl7_reg)) << 32)
                   + 128'(alnl7_reg);

    always_ff @(posedge clk)
    begin
        h28_reg   <= h2_next;
        ac8_reg   <= ac_next;
        kind8_reg <= kind7_reg;
        hmag8_reg <= hmag7_reg;
        hneg8_reg <= hneg7_reg;
        a8_reg    <= a7_reg;
    end

    // discriminant root
    logic [63:0]       sq_root;
    logic [STAG_W-1:0] sq_tag;

    let_sqrt #(
        .R_W   (64),
        .TAG_W (STAG_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v8_reg),
        .radicand  (h28_reg + ac8_reg),
        .in_tag    ({kind8_reg, hneg8_reg, hmag8_reg, a8_reg}),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_tag   (sq_tag)
    );

    // numerator s - h, then time = num * 2^TFB / a
    logic [1:0]  sq_kind;
    logic        sq_hneg;
    logic [61:0] sq_hmag;
    logic [61:0] sq_a;
    logic [63:0] num;
    logic [31:0] td_q;
    logic        td_ovf;
    logic [1:0]  td_tag;

    assign sq_kind = sq_tag[STAG_W-1 -: 2];
    assign sq_hneg = sq_tag[124];
    assign sq_hmag = sq_tag[123:62];
    assign sq_a    = sq_tag[61:0];
    assign num     = sq_hneg ? (sq_root + 64'(sq_hmag)) : (sq_root - 64'(sq_hmag));

    let_div #(
        .N_W   (64 + TFB),
        .D_W   (62),
        .Q_W   (let_pkg::OUT_W),
        .TAG_W (2)
    ) u_tdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .dividend  ({num, {TFB{1'b0}}}),
        .divisor   (sq_a),
        .in_tag    (sq_kind),
        .out_valid (td_valid),
        .quotient  (td_q),
        .overflow  (td_ovf),
        .out_tag   (td_tag)
    );

    // output register
    logic [31:0] expiry_next;
    logic        sat_next;
    logic [31:0] expiry_reg;
    logic        sat_reg;

    always_comb
    begin
        expiry_next = '0;
        sat_next    = 1'b0;
        case (let_pkg::kind_t'(td_tag))
            let_pkg::KIND_CALC:
            begin
                expiry_next = td_ovf ? '1 : td_q;
                sat_next    = td_ovf;
            end
            let_pkg::KIND_ONE:
            begin
                expiry_next = 32'(1) << TFB;
            end
            default:
            begin
                expiry_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        expiry_reg <= expiry_next;
        sat_reg    <= sat_next;
    end

    assign done        = done_reg;
    assign expiry_time = expiry_reg;
    assign saturated   = sat_reg;

endmodule

>>> tb/link_expiration_time_tb.sv
// ----------------------------------------------------------------------------
// link_expiration_time_tb
// Self-checking bench for the link expiration time block. It drives directed
// and random neighbor records under several range and timeout settings,
// predicts each expiry time and saturation flag, and checks every done strobe
// in order against the predicted value.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module link_expiration_time_tb;

    localparam int DRAIN_CYCLES = 160;
    localparam int STALL_LIMIT  = 5000;

    typedef struct {
        logic signed [let_pkg::POS_W-1:0] rel_pos [3];
        logic signed [let_pkg::VEL_W-1:0] nbr_vel [3];
        logic [let_pkg::ELA_W-1:0]        elapsed;
        logic signed [let_pkg::POS_W-1:0] own_disp [3];
    } nbr_rec_t;

    typedef struct {
        logic [let_pkg::OUT_W-1:0] expiry;
        logic                      sat;
    } expiry_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [31:0] rel_pos_x, rel_pos_y, rel_pos_z;
    logic signed [23:0] nbr_vel_x, nbr_vel_y, nbr_vel_z;
    logic [23:0] elapsed;
    logic signed [31:0] own_disp_x, own_disp_y, own_disp_z;
    logic done;
    logic [31:0] expiry_time;
    logic saturated;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [23:0] cfg_data;

    // shadow copy of the registers
    logic [let_pkg::CR_W-1:0] range_reg;
    logic [let_pkg::TO_W-1:0] timeout_reg;

    expiry_t expiry_q [$];
    int  mismatches;
    bit  accepted;

    link_expiration_time dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .rel_pos_x(rel_pos_x), .rel_pos_y(rel_pos_y), .rel_pos_z(rel_pos_z),
        .nbr_vel_x(nbr_vel_x), .nbr_vel_y(nbr_vel_y), .nbr_vel_z(nbr_vel_z),
        .elapsed(elapsed),
        .own_disp_x(own_disp_x), .own_disp_y(own_disp_y), .own_disp_z(own_disp_z),
        .done(done), .expiry_time(expiry_time), .saturated(saturated),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // clamp to the datapath limit
    function automatic longint clamp_lim(input longint x);
        if (x > let_pkg::CLAMP_LIM) return let_pkg::CLAMP_LIM;
        if (x < -let_pkg::CLAMP_LIM) return -let_pkg::CLAMP_LIM;
        return x;
    endfunction

    // expiry time for one neighbor record
    function automatic expiry_t predict_expiry(input nbr_rec_t r);
        expiry_t res;
        longint tdiv, el, pk, vk, vj, disp, dmag, vi, a, h, pp, c, hmag;
        logic [127:0] d, s, y;
        logic signed [127:0] num, q, t;
        a = 0;
        h = 0;
        pp = 0;
        res.expiry = '0;
        res.sat = 1'b0;
        tdiv = (timeout_reg == 0) ? (64'sd1 <<< let_pkg::TFB)
                                  : longint'({44'd0, timeout_reg});
        el = longint'({40'd0, r.elapsed});
        for (int k = 0; k < 3; k++)
        begin
            vj = longint'(r.nbr_vel[k]);
            disp = longint'(r.own_disp[k]);
            pk = longint'(r.rel_pos[k]) + ((vj * el) >>> let_pkg::TFB);
            dmag = (disp < 0) ? -disp : disp;
            vi = (dmag <<< let_pkg::TFB) / tdiv;
            if (disp < 0) vi = -vi;
            vk = clamp_lim(vj - vi);
            pk = clamp_lim(pk);
            a += vk * vk;
            h += pk * vk;
            pp += pk * pk;
        end
        c = pp - longint'({40'd0, range_reg}) * longint'({40'd0, range_reg});
        if (a == 0)
        begin
            if (c < 0) res.expiry = 32'd1 << let_pkg::TFB;
            return res;
        end
        if (c >= 0) return res;
        hmag = (h < 0) ? -h : h;
        d = 128'(hmag) * 128'(hmag) + 128'(a) * 128'(-c);
        s = '0;
        for (int b = 63; b >= 0; b--)
        begin
            y = s | (128'd1 << b);
            if (y * y <= d) s = y;
        end
        num = $signed(s) - 128'(h);
        q = num / 128'(a);
        if (q > (32'hFFFF_FFFF >> let_pkg::TFB))
        begin
            res.expiry = 32'hFFFF_FFFF;
            res.sat = 1'b1;
        end
        else
        begin
            t = (num <<< let_pkg::TFB) / 128'(a);
            res.expiry = t[31:0];
        end
        return res;
    endfunction

    function automatic int rnd_s(input int lim);
        return int'($urandom_range(2 * lim)) - lim;
    endfunction

    // fully random record, every bit free
    function automatic nbr_rec_t rand_rec();
        nbr_rec_t r;
        for (int k = 0; k < 3; k++)
        begin
            r.rel_pos[k] = $urandom;
            r.nbr_vel[k] = 24'($urandom);
            r.own_disp[k] = $urandom;
        end
        r.elapsed = 24'($urandom);
        return r;
    endfunction

    // neighbor inside range with moderate motion
    function automatic nbr_rec_t inside_rec();
        nbr_rec_t r;
        int lim;
        lim = (range_reg > 4) ? int'(range_reg / 2) : 1;
        if (lim > 1 << 28) lim = 1 << 28;
        for (int k = 0; k < 3; k++)
        begin
            r.rel_pos[k] = rnd_s(lim);
            r.nbr_vel[k] = 24'(rnd_s(1 << ($urandom_range(16))));
            r.own_disp[k] = rnd_s(1 << ($urandom_range(20)));
        end
        r.elapsed = 24'($urandom_range(1 << 12));
        return r;
    endfunction

    // one request on the command port
    task automatic send_rec(input nbr_rec_t r, input bit keep_start);
        start <= 1'b1;
        rel_pos_x <= r.rel_pos[0];
        rel_pos_y <= r.rel_pos[1];
        rel_pos_z <= r.rel_pos[2];
        nbr_vel_x <= r.nbr_vel[0];
        nbr_vel_y <= r.nbr_vel[1];
        nbr_vel_z <= r.nbr_vel[2];
        elapsed <= r.elapsed;
        own_disp_x <= r.own_disp[0];
        own_disp_y <= r.own_disp[1];
        own_disp_z <= r.own_disp[2];
        forever
        begin
            @(posedge clk);
            if (!busy) break;
        end
        expiry_q.insert(expiry_q.size(), predict_expiry(r));
        @(negedge clk);
        if (!keep_start) start <= 1'b0;
    endtask

    task automatic send_paced(input nbr_rec_t r);
        int gap;
        gap = $urandom_range(5);
        send_rec(r, gap == 0);
        repeat (gap) @(negedge clk);
    endtask

    task automatic wait_drain();
        start <= 1'b0;
        while (expiry_q.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // register write request, block idle
    task automatic write_cfg(input logic [1:0] idx, input logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        forever
        begin
            @(posedge clk);
            if (cfg_ready) break;
        end
        if (idx == let_pkg::CFG_COMM_RANGE) range_reg = val;
        else if (idx == let_pkg::CFG_RELIABILITY_TIMEOUT) timeout_reg = val[let_pkg::TO_W-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic test_directed();
        nbr_rec_t r;
        // at rest inside range, then at rest on the edge
        r = '{rel_pos: '{0, 0, 0}, nbr_vel: '{0, 0, 0}, elapsed: 0, own_disp: '{0, 0, 0}};
        send_paced(r);
        r.rel_pos[0] = 32'(range_reg);
        send_paced(r);
        // moving away from the center
        r.rel_pos[0] = 0;
        r.nbr_vel[0] = 256;
        send_paced(r);
        // approaching from inside, receding from inside
        r.rel_pos[1] = 30000;
        r.nbr_vel[1] = -512;
        send_paced(r);
        r.nbr_vel[1] = 512;
        send_paced(r);
        // outside range, moving in and out
        r.rel_pos[1] = 32'sh7FFF_FFFF;
        send_paced(r);
        r.rel_pos[1] = 32'sh8000_0000;
        send_paced(r);
        // own motion cancels neighbor motion
        r = '{rel_pos: '{100, 0, 0}, nbr_vel: '{256, 0, 0}, elapsed: 0,
              own_disp: '{256, 0, 0}};
        send_paced(r);
        // extreme fields
        r = '{rel_pos: '{32'sh7FFF_FFFF, 32'sh8000_0000, 0},
              nbr_vel: '{24'sh7F_FFFF, 24'sh80_0000, 24'sh7F_FFFF},
              elapsed: 24'hFF_FFFF,
              own_disp: '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000}};
        send_paced(r);
        r.elapsed = 0;
        send_paced(r);
        // slow drift, long time
        r = '{rel_pos: '{0, 0, 0}, nbr_vel: '{1, 0, 0}, elapsed: 24'hFF_FFFF,
              own_disp: '{0, 0, 0}};
        send_paced(r);
        r.elapsed = 0;
        send_paced(r);
        for (int i = 0; i < 8; i++) send_paced(inside_rec());
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) < 7) send_paced(inside_rec());
            else send_paced(rand_rec());
            // sender holds off until the pipeline is empty
            if (i == n / 2)
            begin
                start <= 1'b0;
                while (expiry_q.size() != 0) @(negedge clk);
            end
        end
    endtask

    task automatic test_config(input logic [23:0] rng, input logic [23:0] tmo, input int n);
        wait_drain();
        write_cfg(let_pkg::CFG_COMM_RANGE, rng);
        write_cfg(let_pkg::CFG_RELIABILITY_TIMEOUT, tmo);
        // unused indexes must be ignored
        write_cfg(2'd2, 24'($urandom));
        write_cfg(2'd3, 24'($urandom));
        test_directed();
        test_random(n);
    endtask

    // result checker
    always @(posedge clk)
    begin
        expiry_t e;
        if (rst_n && done)
        begin
            if (expiry_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h %b", expiry_time, saturated);
            end
            else
            begin
                e = expiry_q.pop_front();
                if (e.expiry !== expiry_time || e.sat !== saturated)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h sat %b, got %h sat %b",
                                 e.expiry, e.sat, expiry_time, saturated);
                end
            end
        end
    end

    // watchdog on stalled traffic
    always @(posedge clk)
    begin
        int idle_cnt;
        if ((start && !busy) || done || (cfg_valid && cfg_ready) || !rst_n) idle_cnt = 0;
        else idle_cnt++;
        if (idle_cnt >= STALL_LIMIT)
        begin
            $display("link_expiration_time_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rel_pos_x = '0; rel_pos_y = '0; rel_pos_z = '0;
        nbr_vel_x = '0; nbr_vel_y = '0; nbr_vel_z = '0;
        elapsed = '0;
        own_disp_x = '0; own_disp_y = '0; own_disp_z = '0;
        mismatches = 0;
        range_reg = 24'd64000;
        timeout_reg = 20'd1024;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        // reset register values
        test_directed();
        test_random(150);
        test_config(24'hFF_FFFF, 24'h00_0000, 120);
        test_config(24'h00_0000, 24'hFF_FFFF, 60);
        test_config(24'd1, 24'd1, 60);
        test_config(24'($urandom), 24'($urandom), 120);
        test_config(24'($urandom_range(200000)), 24'($urandom_range(4096)), 120);
        wait_drain();
        if (mismatches == 0 && expiry_q.size() == 0)
            $display("link_expiration_time_tb: PASS");
        else
            $display("link_expiration_time_tb: FAIL");
        $finish;
    end

endmodule

>>> files.f
src/let_pkg.sv
src/let_div.sv
src/let_sqrt.sv
src/link_expiration_time.sv
tb/link_expiration_time_tb.sv
